### hw/rtl/heap_region_access_checker_assert.svh
`ifndef HEAP_REGION_ACCESS_CHECKER_ASSERT_SVH
`define HEAP_REGION_ACCESS_CHECKER_ASSERT_SVH

// ante implies cons in the same cycle
`define HRAC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heap region access checker: property failed");

// ante implies cons in the next cycle
`define HRAC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heap region access checker: property failed");

`endif

### hw/rtl/hrac_pkg.sv
`timescale 1ns / 1ps

package hrac_pkg;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_CHECK = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NEG_ADDR = 3'd1;
   localparam logic [2:0] ST_NEG_SIZE = 3'd2;
   localparam logic [2:0] ST_UNKNOWN  = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_OUTSIDE  = 3'd5;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic        live;
      logic [30:0] size;
      logic [30:0] base;
   } entry_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_busy;
   } stat_type;

endpackage

### hw/rtl/hrac_ctrl.sv
`timescale 1ns / 1ps

module hrac_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  hrac_pkg::stat_type stat,
   output hrac_pkg::cmd_type  cmd
);

   hrac_pkg::state_type state_ff;
   hrac_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrac_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hrac_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = hrac_pkg::S_SCAN;
            end
         end
         hrac_pkg::S_SCAN: begin
            if (stat.scan_done) begin
               state_in = hrac_pkg::S_FINISH;
            end
         end
         hrac_pkg::S_FINISH: begin
            if (!stat.out_busy) begin
               state_in = hrac_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = hrac_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         hrac_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         hrac_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
         end
         hrac_pkg::S_FINISH: begin
            cmd.commit = !stat.out_busy;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

### hw/rtl/hrac_datapath.sv
`timescale 1ns / 1ps

module hrac_datapath #(
   parameter int MAX_REGIONS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [hrac_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [7:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [hrac_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  hrac_pkg::cmd_type                   cmd,
   output hrac_pkg::stat_type                  stat
);

   localparam int CW   = $clog2(MAX_REGIONS + 1);
   localparam int IDXW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

   hrac_pkg::entry_type table_mem [MAX_REGIONS];

   logic [1:0]          func_ff;
   logic [31:0]         addr_ff;
   logic [30:0]         len_ff;
   logic signed [32:0]  end_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff;
   logic                rd_pend_ff;
   hrac_pkg::entry_type rd_data_ff;
   logic                match_ff;
   logic [IDXW-1:0]     match_idx_ff;
   logic [30:0]         match_size_ff;
   logic [30:0]         min_base_ff;
   logic                inside_ff;
   logic                rsp_tvalid_ff;
   logic [hrac_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;

   logic                issue;
   logic [31:0]         ent_end;
   logic                hit_base;
   logic                hit_inside;
   logic                wr_en;
   logic [IDXW-1:0]     wr_idx;
   hrac_pkg::entry_type wr_data;
   logic [2:0]          status;
   logic [30:0]         ret_base;

   assign issue      = cmd.scan && (idx_ff < count_ff);
   assign ent_end    = {1'b0, rd_data_ff.base} + {1'b0, rd_data_ff.size};
   assign hit_base   = ({1'b0, rd_data_ff.base} == addr_ff);
   assign hit_inside = rd_data_ff.live
                       && ($signed({2'b00, rd_data_ff.base}) <= $signed({addr_ff[31], addr_ff}))
                       && (end_ff <= $signed({1'b0, ent_end}));

   assign stat.scan_done = (idx_ff == count_ff) && !rd_pend_ff;
   assign stat.out_busy  = rsp_tvalid_ff && !rsp_tready;

   // decide the result and the table update from the finished scan
   always_comb begin
      status   = hrac_pkg::ST_OK;
      ret_base = '0;
      wr_en    = 1'b0;
      wr_idx   = match_idx_ff;
      wr_data  = '{live: 1'b1, size: len_ff, base: addr_ff[30:0]};
      count_in = count_ff;
      case (func_ff)
         hrac_pkg::FUNC_ALLOC: begin
            if (addr_ff[31]) begin
               status = hrac_pkg::ST_NEG_ADDR;
            end else if (match_ff) begin
               wr_en    = 1'b1;
               ret_base = addr_ff[30:0];
            end else if (count_ff < CW'(MAX_REGIONS)) begin
               wr_en    = 1'b1;
               wr_idx   = count_ff[IDXW-1:0];
               count_in = count_ff + CW'(1);
               ret_base = addr_ff[30:0];
            end else begin
               status = hrac_pkg::ST_FULL;
            end
         end
         hrac_pkg::FUNC_FREE: begin
            wr_data = '{live: 1'b0, size: match_size_ff, base: addr_ff[30:0]};
            if (addr_ff[31]) begin
               status = hrac_pkg::ST_NEG_ADDR;
            end else if (match_ff) begin
               wr_en = 1'b1;
            end else begin
               status = hrac_pkg::ST_UNKNOWN;
            end
         end
         hrac_pkg::FUNC_CHECK: begin
            if ((count_ff != '0) && !addr_ff[31] && (addr_ff[30:0] >= min_base_ff)
                && !inside_ff) begin
               status = hrac_pkg::ST_OUTSIDE;
            end
         end
         default: begin
            status = hrac_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         table_mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= table_mem[idx_ff[IDXW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         idx_ff        <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= issue;
         if (cmd.start) begin
            idx_ff <= '0;
         end else if (issue) begin
            idx_ff <= idx_ff + CW'(1);
         end
         if (cmd.commit) begin
            count_ff      <= count_in;
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         func_ff     <= req_tuser[1:0];
         addr_ff     <= req_tdata[31:0];
         len_ff      <= req_tdata[62:32];
         end_ff      <= $signed({req_tdata[31], req_tdata[31:0]})
                        + $signed({2'b00, req_tdata[62:32]});
         match_ff    <= 1'b0;
         min_base_ff <= '1;
         inside_ff   <= 1'b0;
      end else if (rd_pend_ff) begin
         if (hit_base) begin
            match_ff      <= 1'b1;
            match_idx_ff  <= idx_ff[IDXW-1:0] - IDXW'(1);
            match_size_ff <= rd_data_ff.size;
         end
         if (rd_data_ff.base < min_base_ff) begin
            min_base_ff <= rd_data_ff.base;
         end
         if (hit_inside) begin
            inside_ff <= 1'b1;
         end
      end
      if (cmd.commit) begin
         rsp_tdata_ff <= {6'd0, ret_base, status};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

### hw/rtl/heap_region_access_checker.sv
`timescale 1ns / 1ps
// channel   direction  ports                      payload
// req       in         req_tvalid/tready/tdata/   func, addr, length
//                      tuser
// rsp       out        rsp_tvalid/tready/tdata    status, returned_base
//
// The scan reads the entries in use (at most MAX_REGIONS) through one registered read
// port, one entry a cycle. The next request can be accepted in the same cycle that the
// result first shows as valid on rsp.
// Reset clears the fill count but not the table entries; entries above the count are never used.
// A new request is accepted while the previous result waits in the output
// register; a stalled result holds the finish step until it is taken.

module heap_region_access_checker #(
   parameter int MAX_REGIONS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [hrac_pkg::REQ_DATA_W-1:0] req_tdata,  // addr[31:0], length[62:32]
   input  logic [7:0]                      req_tuser,  // func[1:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [hrac_pkg::RSP_DATA_W-1:0] rsp_tdata   // status[2:0], returned_base[33:3]
);

   hrac_pkg::cmd_type  cmd;
   hrac_pkg::stat_type stat;

   hrac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   hrac_datapath #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

### hw/rtl/hrac_checker.sv
`timescale 1ns / 1ps
`include "heap_region_access_checker_assert.svh"

module hrac_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [hrac_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [7:0]                      req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [hrac_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   `HRAC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `HRAC_ASSERT_NOW(a_base_only_ok, clock, reset, rsp_tvalid, (rsp_tdata[2:0] == hrac_pkg::ST_OK) || (rsp_tdata[33:3] == 31'd0))
   `HRAC_ASSERT_NOW(a_status_known, clock, reset, rsp_tvalid, rsp_tdata[2:0] <= hrac_pkg::ST_OUTSIDE && rsp_tdata[2:0] != hrac_pkg::ST_NEG_SIZE)
   `HRAC_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind heap_region_access_checker hrac_checker u_hrac_checker (.*);

### test/heap_region_access_checker_tb.sv
`timescale 1ns / 1ps

module heap_region_access_checker_tb;

   localparam int MAX_REGIONS = 16;
   localparam int POOL_N = 20;
   localparam int HOLD_CYCLES = 400;
   localparam int LIMIT = 500000;
   localparam logic [1:0] FUNC_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] addr;
      logic [30:0] length;
   } request_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [30:0] base;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [hrac_pkg::REQ_DATA_W-1:0] req_tdata = '0;  // addr[31:0], length[62:32]
   logic [7:0] req_tuser = '0;                       // func[1:0]
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [hrac_pkg::RSP_DATA_W-1:0] rsp_tdata;       // status[2:0], returned_base[33:3]

   request_type request_q[$];
   outcome_type outcome_q[$];

   logic        region_used [MAX_REGIONS];
   logic [30:0] region_base [MAX_REGIONS];
   logic [30:0] region_size [MAX_REGIONS];
   logic        region_live [MAX_REGIONS];

   logic [30:0] base_pool [POOL_N];
   logic [30:0] span_pool [POOL_N];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int holds_asked = 0;
   int holds_done = 0;
   int hold_left = 0;
   int errors = 0;
   int cycles = 0;

   heap_region_access_checker #(.MAX_REGIONS(MAX_REGIONS)) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #4 clock = ~clock;

   // region table shadow: one outcome per request
   function automatic outcome_type judge_request(request_type r);
      outcome_type o;
      int slot;
      int i;
      bit any;
      longint a, fin, low, s, e;
      o.status = hrac_pkg::ST_OK;
      o.base = '0;
      slot = -1;
      any = 1'b0;
      a = longint'($signed(r.addr));
      case (r.func)
         hrac_pkg::FUNC_ALLOC: begin
            if (a < 0) begin
               o.status = hrac_pkg::ST_NEG_ADDR;
            end else begin
               for (i = 0; i < MAX_REGIONS; i++)
                  if (slot < 0 && region_used[i] && region_base[i] == r.addr[30:0]) slot = i;
               for (i = 0; i < MAX_REGIONS; i++)
                  if (slot < 0 && !region_used[i]) slot = i;
               if (slot < 0) begin
                  o.status = hrac_pkg::ST_FULL;
               end else begin
                  region_used[slot] = 1'b1;
                  region_base[slot] = r.addr[30:0];
                  region_size[slot] = r.length;
                  region_live[slot] = 1'b1;
                  o.base = r.addr[30:0];
               end
            end
         end
         hrac_pkg::FUNC_FREE: begin
            if (a < 0) begin
               o.status = hrac_pkg::ST_NEG_ADDR;
            end else begin
               for (i = 0; i < MAX_REGIONS; i++)
                  if (slot < 0 && region_used[i] && region_base[i] == r.addr[30:0]) slot = i;
               if (slot < 0) o.status = hrac_pkg::ST_UNKNOWN;
               else region_live[slot] = 1'b0;
            end
         end
         hrac_pkg::FUNC_CHECK: begin
            fin = a + longint'({33'd0, r.length});
            low = 64'sh7FFF_FFFF_FFFF_FFFF;
            for (i = 0; i < MAX_REGIONS; i++) begin
               if (region_used[i]) begin
                  any = 1'b1;
                  if (longint'({33'd0, region_base[i]}) < low) low = {33'd0, region_base[i]};
               end
            end
            if (any && a >= low) begin
               o.status = hrac_pkg::ST_OUTSIDE;
               for (i = 0; i < MAX_REGIONS; i++) begin
                  if (region_used[i] && region_live[i]) begin
                     s = {33'd0, region_base[i]};
                     e = s + longint'({33'd0, region_size[i]});
                     if (s <= a && fin <= e) o.status = hrac_pkg::ST_OK;
                  end
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int k, roll, pick;
      longint b, span, off, start, rest, len;
      k = $urandom_range(0, POOL_N - 1);
      b = {33'd0, base_pool[k]};
      span = {33'd0, span_pool[k]};
      roll = $urandom_range(0, 99);
      r.func = hrac_pkg::FUNC_CHECK;
      r.addr = $urandom;
      r.length = 31'($urandom);
      if (roll < 24) begin
         r.func = hrac_pkg::FUNC_ALLOC;
         r.addr = b[31:0];
         if ($urandom_range(0, 3) != 0) r.length = span[30:0];
      end else if (roll < 27) begin
         r.func = hrac_pkg::FUNC_ALLOC;
      end else if (roll < 40) begin
         r.func = hrac_pkg::FUNC_FREE;
         r.addr = b[31:0];
      end else if (roll < 43) begin
         r.func = hrac_pkg::FUNC_FREE;
      end else if (roll < 88) begin
         off = longint'($urandom_range(0, span[31:0]));
         start = b + off;
         rest = span - off;
         len = 0;
         pick = $urandom_range(0, 4);
         case (pick)
            0: len = longint'($urandom_range(0, rest[31:0]));
            1: len = rest;
            2: len = rest + longint'($urandom_range(1, 8));
            3: begin
               start = b - longint'($urandom_range(1, 16));
               len = longint'($urandom_range(0, 64));
            end
            default: begin
               start = b + span + longint'($urandom_range(0, 16));
               len = longint'($urandom_range(0, 4));
            end
         endcase
         r.addr = start[31:0];
         r.length = len[30:0];
      end else if (roll < 92) begin
         r.func = FUNC_NONE;
      end else if (roll < 96) begin
         r.func = 2'($urandom_range(0, 3));
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   task automatic wait_drained();
      while (request_q.size() != 0 || outcome_q.size() != 0 || req_tvalid) @(negedge clock);
   endtask

   task automatic run_phase(int n, int idle, int stall, bit hold);
      int i;
      @(negedge clock);
      send_idle_pct = idle;
      stall_pct = stall;
      for (i = 0; i < n; i++) request_q.push_back(random_request());
      if (hold) begin
         repeat (20) @(negedge clock);
         holds_asked++;
      end
      wait_drained();
   endtask

   // request driver
   always @(posedge clock) begin
      request_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            r.func = req_tuser[1:0];
            r.addr = req_tdata[31:0];
            r.length = req_tdata[62:32];
            outcome_q.push_back(judge_request(r));
         end
         if (!req_tvalid || req_tready) begin
            if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               r = request_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {1'b0, r.length, r.addr};
               req_tuser <= {6'd0, r.func};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready, with long hold-offs on demand
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done <= holds_done + 1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // response monitor
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcome_q.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[31:0], 32'd0);
         end else begin
            want = outcome_q.pop_front();
            if (rsp_tdata[2:0] !== want.status)
               report_mismatch("status", {29'd0, rsp_tdata[2:0]}, {29'd0, want.status});
            if (rsp_tdata[33:3] !== want.base)
               report_mismatch("returned_base", {1'b0, rsp_tdata[33:3]}, {1'b0, want.base});
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("heap_region_access_checker_tb: FAIL");
         $finish;
      end
   end

   initial begin
      int i;
      for (i = 0; i < MAX_REGIONS; i++) region_used[i] = 1'b0;
      base_pool[0] = 31'h0;        span_pool[0] = 31'h0;
      base_pool[1] = 31'h1000;     span_pool[1] = 31'h100;
      base_pool[2] = 31'h7FFFFFFF; span_pool[2] = 31'h7FFFFFFF;
      for (i = 3; i < POOL_N; i++) begin
         if (i < 10) base_pool[i] = 31'($urandom_range(32'h2000, 32'h000FFFFF));
         else base_pool[i] = 31'($urandom);
         if (i % 3 == 0) span_pool[i] = 31'($urandom);
         else span_pool[i] = 31'($urandom_range(1, 4096));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      // empty table, negative bases, unknown base
      request_q.push_back('{hrac_pkg::FUNC_CHECK, 32'd100, 31'd5});
      request_q.push_back('{hrac_pkg::FUNC_CHECK, 32'h80000000, 31'h7FFFFFFF});
      request_q.push_back('{hrac_pkg::FUNC_FREE, 32'd0, 31'd0});
      request_q.push_back('{hrac_pkg::FUNC_FREE, 32'h80000000, 31'd0});
      request_q.push_back('{hrac_pkg::FUNC_ALLOC, 32'hFFFFFFFF, 31'h7FFFFFFF});
      // one region: exact fit, overrun, below lowest, zero length at end
      request_q.push_back('{hrac_pkg::FUNC_ALLOC, 32'h1000, 31'h100});
      request_q.push_back('{hrac_pkg::FUNC_CHECK, 32'h1000, 31'h100});
      request_q.push_back('{hrac_pkg::FUNC_CHECK, 32'h1000, 31'h101});
      request_q.push_back('{hrac_pkg::FUNC_CHECK, 32'h0FFF, 31'd1});
      request_q.push_back('{hrac_pkg::FUNC_CHECK, 32'h1100, 31'd0});
      // overwrite with a smaller size, then free twice
      request_q.push_back('{hrac_pkg::FUNC_ALLOC, 32'h1000, 31'h40});
      request_q.push_back('{hrac_pkg::FUNC_CHECK, 32'h1000, 31'h100});
      request_q.push_back('{hrac_pkg::FUNC_FREE, 32'h1000, 31'h7FFFFFFF});
      request_q.push_back('{hrac_pkg::FUNC_FREE, 32'h1000, 31'd0});
      request_q.push_back('{hrac_pkg::FUNC_CHECK, 32'h1010, 31'd1});
      request_q.push_back('{hrac_pkg::FUNC_CHECK, 32'h0, 31'd0});
      // top of the address range, end beyond 31 bits
      request_q.push_back('{hrac_pkg::FUNC_ALLOC, 32'h7FFFFFFF, 31'h7FFFFFFF});
      request_q.push_back('{hrac_pkg::FUNC_CHECK, 32'h7FFFFFFF, 31'h7FFFFFFF});
      request_q.push_back('{hrac_pkg::FUNC_CHECK, 32'h40000000, 31'h7FFFFFFF});
      request_q.push_back('{FUNC_NONE, 32'hFFFFFFFF, 31'h7FFFFFFF});
      // zero-size region at base zero
      request_q.push_back('{hrac_pkg::FUNC_ALLOC, 32'h0, 31'd0});
      request_q.push_back('{hrac_pkg::FUNC_CHECK, 32'h0, 31'd0});
      request_q.push_back('{hrac_pkg::FUNC_CHECK, 32'h0, 31'd1});
      request_q.push_back('{hrac_pkg::FUNC_CHECK, 32'h80000000, 31'h7FFFFFFF});
      wait_drained();

      run_phase(325, 0, 0, 1'b1);
      run_phase(325, 54, 0, 1'b0);
      run_phase(325, 0, 54, 1'b0);
      run_phase(325, 29, 29, 1'b0);

      repeat (40) @(negedge clock);
      if (errors == 0) begin
         $display("heap_region_access_checker_tb: PASS");
      end else begin
         $display("heap_region_access_checker_tb: FAIL");
      end
      $finish;
   end

endmodule
